[design/rgbab_pkg.sv]
// shared widths, constants and types for the rgb565 alpha-over blend pipeline
package rgbab_pkg;

  localparam int ALPHA_W = 8;
  localparam int COLOR_W = 16;
  localparam int CHAN_W  = 6;
  localparam int NCHAN   = 3;
  localparam int NUM_W   = 15;
  localparam int REM_W   = 11;
  localparam int QHI_W   = 3;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;
  localparam logic [CHAN_W-1:0]  RED_MAX   = 6'd31;
  localparam logic [CHAN_W-1:0]  GREEN_MAX = 6'd63;
  localparam logic [CHAN_W-1:0]  BLUE_MAX  = 6'd31;

  // floor(x/255) for x below 2^16: (x * 0x8081) >> 23
  localparam logic [16:0] RECIP255_16 = 17'h08081;
  localparam int          SHIFT255_16 = 23;
  // floor(x/255) for x below 2^22: (x * 0x404041) >> 30
  localparam logic [22:0] RECIP255_22 = 23'h404041;
  localparam int          SHIFT255_22 = 30;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef logic [NUM_W-1:0]   num_t;

endpackage

[design/rgb565_alpha_over_blend_top.sv]
// top level of the rgb565 alpha-over blend pipeline
//
// composites a source rgb565 pixel with alpha over a destination pixel with alpha.
// input channel: in_tvalid/in_tready/in_tdata, one pixel pair per transfer.
// output channel: out_tvalid/out_tready/out_tdata, one blended pixel per transfer.
// five register stages: alpha and channel products, divide by 255 for alpha and
// the attenuated destination term, numerator sum, then two stages of a restoring
// divider by the combined alpha, three quotient bits per stage per channel.
// out_tvalid is the valid bit of the last stage; throughput is one pixel per cycle
// while out_tready stays high.
// the last stage is the output register; when the receiver stalls with a result
// waiting, the whole pipeline holds and in_tready drops, so nothing is lost or
// repeated; empty stages still advance behind a waiting result only when it moves.
// a zero combined alpha gives a zero color.
// reset clears the stage valid bits; the data registers are not reset.
module rgb565_alpha_over_blend_top
  import rgbab_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // dst_color[15:0], dst_alpha[23:16], src_color[39:24], src_alpha[47:40]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_color[15:0], out_alpha[23:16]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int NSTAGE = 5;

  logic              ce;
  logic [NSTAGE-1:0] vld_r, vld_nxt;

  // stage 1
  alpha_t       a1_r1, a2_r1;
  logic [15:0]  pa_r1, pa_nxt;
  logic [15:0]  t_r1, t_nxt;
  chan_t        c1_r1 [NCHAN];
  chan_t        c1_nxt [NCHAN];
  logic [13:0]  sa_r1 [NCHAN];
  logic [13:0]  sa_nxt [NCHAN];

  // stage 2
  alpha_t       a_r2, a_nxt;
  logic [21:0]  u_r2 [NCHAN];
  logic [21:0]  u_nxt [NCHAN];
  logic [13:0]  sa_r2 [NCHAN];

  // stage 3
  alpha_t       a_r3;
  num_t         num_r3 [NCHAN];
  num_t         num_nxt [NCHAN];

  // stages 4 and 5
  alpha_t       a_r4, a_r5;
  chan_t        q_w [NCHAN];
  chan_t        cmax [NCHAN];

  assign ce        = !vld_r[NSTAGE-1] || out_tready;
  assign in_tready = ce;
  assign vld_nxt   = {vld_r[NSTAGE-2:0], in_tvalid};

  assign cmax[CH_RED]   = RED_MAX;
  assign cmax[CH_GREEN] = GREEN_MAX;
  assign cmax[CH_BLUE]  = BLUE_MAX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= vld_nxt;
    end
  end

  // unpack and first products
  always_comb begin
    logic [COLOR_W-1:0] dc;
    logic [COLOR_W-1:0] sc;
    alpha_t             a1;
    alpha_t             a2;
    chan_t              c2 [NCHAN];
    dc = in_tdata[15:0];
    a1 = in_tdata[23:16];
    sc = in_tdata[39:24];
    a2 = in_tdata[47:40];
    c1_nxt[CH_RED]   = {1'b0, dc[15:11]};
    c1_nxt[CH_GREEN] = dc[10:5];
    c1_nxt[CH_BLUE]  = {1'b0, dc[4:0]};
    c2[CH_RED]       = {1'b0, sc[15:11]};
    c2[CH_GREEN]     = sc[10:5];
    c2[CH_BLUE]      = {1'b0, sc[4:0]};
    pa_nxt = a1 * a2;
    t_nxt  = a1 * (ALPHA_MAX - a2);
    for (int i = 0; i < NCHAN; i++) begin
      sa_nxt[i] = c2[i] * a2;
    end
  end

  // combined alpha and destination term
  always_comb begin
    logic [32:0] pd;
    logic [8:0]  asum;
    pd   = {16'd0, pa_r1} * {16'd0, RECIP255_16};
    asum = {1'b0, a1_r1} + {1'b0, a2_r1} - {1'b0, pd[SHIFT255_16 +: ALPHA_W]};
    a_nxt = asum[ALPHA_W-1:0];
    for (int i = 0; i < NCHAN; i++) begin
      u_nxt[i] = c1_r1[i] * t_r1;
    end
  end

  // numerator per channel
  always_comb begin
    logic [44:0] w;
    for (int i = 0; i < NCHAN; i++) begin
      w          = {23'd0, u_r2[i]} * {22'd0, RECIP255_22};
      num_nxt[i] = {1'b0, w[SHIFT255_22 +: 14]} + {1'b0, sa_r2[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a1_r1  <= in_tdata[23:16];
      a2_r1  <= in_tdata[47:40];
      pa_r1  <= pa_nxt;
      t_r1   <= t_nxt;
      a_r2   <= a_nxt;
      a_r3   <= a_r2;
      a_r4   <= a_r3;
      a_r5   <= a_r4;
      for (int i = 0; i < NCHAN; i++) begin
        c1_r1[i]  <= c1_nxt[i];
        sa_r1[i]  <= sa_nxt[i];
        u_r2[i]   <= u_nxt[i];
        sa_r2[i]  <= sa_r1[i];
        num_r3[i] <= num_nxt[i];
      end
    end
  end

  for (genvar g = 0; g < NCHAN; g++) begin : g_div
    rgbab_div u_div (
      .clk     (clk),
      .en      (ce),
      .num_i   (num_r3[g]),
      .den_i   (a_r3),
      .sat_max (cmax[g]),
      .q_o     (q_w[g])
    );
  end

  assign out_tvalid = vld_r[NSTAGE-1];
  assign out_tdata  = {a_r5, q_w[CH_RED][4:0], q_w[CH_GREEN], q_w[CH_BLUE][4:0]};

`ifndef SYNTH
  // transparent result carries no color
  a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[23:16] == '0)) |-> (out_tdata[15:0] == '0))
    else $error("zero alpha with nonzero color");

  // a stalled result freezes every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

[design/rgbab_div.sv]
// two-stage restoring divider for one color channel with saturation and zero-alpha clear
module rgbab_div
  import rgbab_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  num_t   num_i,
  input  alpha_t den_i,
  input  chan_t  sat_max,
  output chan_t  q_o
);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QHI_W-1:0] qhi_r, qhi_nxt;
  logic             sat_r, sat_nxt;
  alpha_t           den_r;
  chan_t            q_r, q_nxt;

  // upper quotient bits and overflow check
  always_comb begin
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] dsh;
    rem     = num_i;
    qhi_nxt = '0;
    sat_nxt = (num_i >= {1'b0, den_i, 6'd0});
    for (int k = CHAN_W - 1; k >= CHAN_W - QHI_W; k--) begin
      dsh = {7'd0, den_i} << k;
      if (rem >= dsh) begin
        rem = rem - dsh;
        qhi_nxt[k - (CHAN_W - QHI_W)] = 1'b1;
      end
    end
    rem_nxt = rem[REM_W-1:0];
  end

  // lower quotient bits, clamp and clear
  always_comb begin
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dsh;
    logic [2:0]       qlo;
    chan_t            q;
    rem = rem_r;
    qlo = '0;
    for (int k = CHAN_W - QHI_W - 1; k >= 0; k--) begin
      dsh = {3'd0, den_r} << k;
      if (rem >= dsh) begin
        rem    = rem - dsh;
        qlo[k] = 1'b1;
      end
    end
    q = {qhi_r, qlo};
    if (den_r == '0) begin
      q_nxt = '0;
    end else if (sat_r || (q > sat_max)) begin
      q_nxt = sat_max;
    end else begin
      q_nxt = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      qhi_r <= qhi_nxt;
      sat_r <= sat_nxt;
      den_r <= den_i;
      q_r   <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule
